// ----- hdl/capped_exponential_backoff_jitter_defines.svh -----
// Assertion macros used by the checker file
`ifndef CAPPED_EXPONENTIAL_BACKOFF_JITTER_DEFINES_SVH
`define CAPPED_EXPONENTIAL_BACKOFF_JITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CEBJ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CEBJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/cebj_pkg.sv -----
// Shared types and constants for the backoff delay generator
package cebj_pkg;

  localparam int unsigned GfW    = 16;
  localparam int unsigned DelayW = 32;
  localparam int unsigned LimitW = 17;
  localparam int unsigned JitW   = 17;
  localparam int unsigned PowW   = 48;
  localparam int unsigned HalfW  = 24;
  localparam int unsigned ProdW  = 56;
  localparam int unsigned AccW   = 66;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_GROWTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT  = 2'd2;

  localparam logic [GfW-1:0]    GrowthRst = 16'd8192;
  localparam logic [DelayW-1:0] MaxRst    = 32'd1000000;
  localparam logic [LimitW-1:0] LimitRst  = 17'd20;
  localparam logic [PowW-1:0]   PowerOne  = 48'd65536;
  localparam logic [PowW-1:0]   PowerMax  = {PowW{1'b1}};

  localparam logic [31:0] RndAdv = 32'd2048;
  localparam logic [31:0] RndDly = 32'd0;
  localparam logic [31:0] RndJit = 32'h8000_0000;

  // Control word for the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;    // register a product
    logic b_hi;      // take the upper half of operand b
    logic acc_load;  // acc = rnd + product
    logic acc_add;   // acc = acc + (product << 24)
  } cebj_cmd_t;

endpackage

// ----- hdl/cebj_mac.sv -----
// Shared multiply-accumulate unit: 32x24 multiplier, product register, 66-bit accumulator
module cebj_mac
  import cebj_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cebj_cmd_t         cmd_i,
  input  logic [31:0]       a_i,
  input  logic [PowW-1:0]   b_i,
  input  logic [31:0]       rnd_i,
  output logic [AccW-1:0]   acc_o,
  output logic              prod_hi_nz_o
);

  logic [ProdW-1:0] prod_q, prod_d;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [HalfW-1:0] b_half;

  assign b_half = cmd_i.b_hi ? b_i[PowW-1:HalfW] : b_i[HalfW-1:0];

  always_comb begin
    prod_d = prod_q;
    acc_d  = acc_q;
    if (cmd_i.mul_en) begin
      prod_d = a_i * b_half;
    end
    if (cmd_i.acc_load) begin
      acc_d = {34'd0, rnd_i} + {{(AccW-ProdW){1'b0}}, prod_q};
    end else if (cmd_i.acc_add) begin
      acc_d = acc_q + {prod_q[AccW-HalfW-1:0], {HalfW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
      acc_q  <= '0;
    end else begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
    end
  end

  assign acc_o        = acc_q;
  assign prod_hi_nz_o = |prod_q[ProdW-1:HalfW];

endmodule

// ----- hdl/capped_exponential_backoff_jitter.sv -----
// Sequence: an accepted next beat runs the power update when the attempt advances, then base
// scaling and jitter scaling, before its delay beat; a skip runs only the power update, or nothing.
// One item at a time: the single shared 32x24 multiplier runs each of the three split products
// (power update, base scaling, jitter scaling) through the states MUL_LO, MUL_HI, ACC_HI, FINISH.
// Reset: configuration registers return to their defaults, attempt count to 0 and growth power to 1.0.
module capped_exponential_backoff_jitter
  import cebj_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DelayW-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [DelayW-1:0]  base_delay_us_i,
  input  logic [JitW-1:0]    jitter_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DelayW-1:0]  delay_us_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_ACC_HI, ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    JOB_ADV, JOB_DLY, JOB_JIT
  } job_e;

  state_e state_q, state_d;
  job_e   job_q, job_d;

  logic [GfW-1:0]    gf_q, gf_d;
  logic [DelayW-1:0] max_q, max_d;
  logic [LimitW-1:0] limit_q, limit_d;
  logic [LimitW-1:0] count_q, count_d;
  logic [PowW-1:0]   power_q, power_d;
  logic              op_q, op_d;
  logic [DelayW-1:0] base_q, base_d;
  logic [JitW-1:0]   jit_q, jit_d;
  logic [PowW-1:0]   m_q, m_d;
  logic              hi_nz_q, hi_nz_d;
  logic              out_valid_q, out_valid_d;
  logic [DelayW-1:0] delay_q, delay_d;

  cebj_cmd_t         cmd;
  logic [31:0]       mac_a;
  logic [PowW-1:0]   mac_b;
  logic [31:0]       mac_rnd;
  logic [AccW-1:0]   acc;
  logic              prod_hi_nz;
  logic [PowW-1:0]   cap;
  logic              in_fire;

  assign cap     = {max_q, 16'd0};
  assign in_fire = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    case (job_q)
      JOB_ADV: begin
        mac_a   = {16'd0, gf_q};
        mac_b   = power_q;
        mac_rnd = RndAdv;
      end
      JOB_DLY: begin
        mac_a   = base_q;
        mac_b   = power_q;
        mac_rnd = RndDly;
      end
      JOB_JIT: begin
        mac_a   = {15'd0, jit_q};
        mac_b   = m_q;
        mac_rnd = RndJit;
      end
      default: begin
        mac_a   = '0;
        mac_b   = '0;
        mac_rnd = '0;
      end
    endcase
  end

  cebj_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .a_i          (mac_a),
    .b_i          (mac_b),
    .rnd_i        (mac_rnd),
    .acc_o        (acc),
    .prod_hi_nz_o (prod_hi_nz)
  );

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    gf_d        = gf_q;
    max_d       = max_q;
    limit_d     = limit_q;
    count_d     = count_q;
    power_d     = power_q;
    op_d        = op_q;
    base_d      = base_q;
    jit_d       = jit_q;
    m_d         = m_q;
    hi_nz_d     = hi_nz_q;
    out_valid_d = out_valid_q && !out_ready_i;
    delay_d     = delay_q;
    cmd         = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GROWTH: gf_d    = cfg_wdata_i[GfW-1:0];
        CFG_MAX:    max_d   = cfg_wdata_i;
        CFG_LIMIT:  limit_d = cfg_wdata_i[LimitW-1:0];
        default:    ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d   = op_i;
          base_d = base_delay_us_i;
          jit_d  = jitter_i;
          if (count_q < limit_q) begin
            job_d   = JOB_ADV;
            state_d = ST_MUL_LO;
          end else if (!op_i) begin
            job_d   = JOB_DLY;
            state_d = ST_MUL_LO;
          end
        end
      end
      ST_MUL_LO: begin
        cmd.mul_en = 1'b1;
        state_d    = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_en   = 1'b1;
        cmd.b_hi     = 1'b1;
        cmd.acc_load = 1'b1;
        state_d      = ST_ACC_HI;
      end
      ST_ACC_HI: begin
        cmd.acc_add = 1'b1;
        hi_nz_d     = prod_hi_nz;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        case (job_q)
          JOB_ADV: begin
            power_d = (acc[AccW-1:60] != '0) ? PowerMax : acc[59:12];
            count_d = count_q + 1'b1;
            if (op_q) begin
              state_d = ST_IDLE;
            end else begin
              job_d   = JOB_DLY;
              state_d = ST_MUL_LO;
            end
          end
          JOB_DLY: begin
            // clamp to max; a nonzero upper product already exceeds any cap
            if (hi_nz_q || (acc[AccW-1:PowW] != '0) || (acc[PowW-1:0] >= cap)) begin
              m_d = cap;
            end else begin
              m_d = acc[PowW-1:0];
            end
            job_d   = JOB_JIT;
            state_d = ST_MUL_LO;
          end
          JOB_JIT: begin
            // hold until the output register is free
            if (!out_valid_q || out_ready_i) begin
              out_valid_d = 1'b1;
              delay_d     = (acc[AccW-1:64] != '0) ? {DelayW{1'b1}} : acc[63:32];
              state_d     = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_q       <= JOB_ADV;
      gf_q        <= GrowthRst;
      max_q       <= MaxRst;
      limit_q     <= LimitRst;
      count_q     <= '0;
      power_q     <= PowerOne;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      gf_q        <= gf_d;
      max_q       <= max_d;
      limit_q     <= limit_d;
      count_q     <= count_d;
      power_q     <= power_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    base_q  <= base_d;
    jit_q   <= jit_d;
    m_q     <= m_d;
    hi_nz_q <= hi_nz_d;
    delay_q <= delay_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign delay_us_o  = delay_q;

endmodule

// ----- hdl/cebj_checker.sv -----
// Port-level checker for the backoff delay generator, bound to the top level
`include "capped_exponential_backoff_jitter_defines.svh"

module cebj_checker
  import cebj_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              op_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [DelayW-1:0] delay_us_o
);

  // a stalled result beat holds
  `CEBJ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(delay_us_o))

  // a next request always occupies the unit
  `CEBJ_ASSERT_NEXT(a_busy_after_next, clk_i, rst_ni, in_valid_i && in_ready_o && !op_i, !in_ready_o)

  // no result can appear the cycle after an accept
  `CEBJ_ASSERT_NEXT(a_no_instant_out, clk_i, rst_ni, in_valid_i && in_ready_o, !$rose(out_valid_o))

  // a result is issued only while the unit is busy
  `CEBJ_ASSERT_NOW(a_out_from_busy, clk_i, rst_ni, $rose(out_valid_o), !$past(in_ready_o))

endmodule

bind capped_exponential_backoff_jitter cebj_checker u_cebj_checker (.*);
